FILE: rtl/rhhs_pkg.sv
// ----------------------------------------------------------------------------
// rhhs_pkg: shared types and constants for the robin hood hash set
// Slot count, widths, request codes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package rhhs_pkg;

    localparam int SLOTS     = 1024;
    localparam int KEY_BITS  = 32;
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int DIST_W    = 10;
    localparam int CFG_W     = 11;
    localparam int HB_W      = 10;

    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [DIST_W-1:0]   dist_t;
    typedef logic [KEY_BITS-1:0] key_t;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_RANGE  = 2'd2,
        ST_UNUSED = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_FRD,
        S_FCHK,
        S_IRD,
        S_ICHK,
        S_RRD,
        S_RCHK,
        S_RCLR,
        S_DONE
    } state_t;

    // one table slot as read from or written to the store
    typedef struct packed {
        logic  valid;
        key_t  key;
        dist_t pdist;
    } slot_t;

    // port between sequencer and slot store
    typedef struct packed {
        logic  rd_en;
        idx_t  rd_addr;
        logic  wr_en;
        idx_t  wr_addr;
        slot_t wr_data;
    } mem_req_t;

    // next slot with wrap at the live slot count
    function automatic idx_t wrap_next(idx_t i, cnt_t n);
        cnt_t s;
        s = {1'b0, i} + cnt_t'(1);
        wrap_next = (s >= n) ? idx_t'(0) : s[IDX_W-1:0];
    endfunction

endpackage

FILE: rtl/robin_hood_hash_set.sv
// ----------------------------------------------------------------------------
// robin_hood_hash_set: open-addressed key set with robin hood probing
// Lookup, insert with displacement, and remove with backward shift.
// ----------------------------------------------------------------------------
//  channel  | signals                              | transfer when
//  request  | valid ready func key home_bucket     | valid & ready
//  result   | out_valid out_ready found status     | out_valid & out_ready
//  config   | psel penable pwrite paddr pwdata     | psel & penable & pwrite
//
// Each request probes slot by slot, reading a slot and then comparing and
// writing it, through one slot store with a read port and a write port;
// an insert probes the find run and then the displacement run, a remove the
// find run and then the shift run, plus a clearing step if the shift spans the table.
// After reset and after every write to the slot count register a clearing
// pass over all slots empties the store; no request is taken meanwhile.
// The result sits in an output register; a stalled result holds the block.
module robin_hood_hash_set
    import rhhs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    output logic                ready,
    input  logic [1:0]          func,
    input  logic [KEY_BITS-1:0] key,
    input  logic [HB_W-1:0]     home_bucket,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                found,
    output logic [1:0]          status,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    state_t   state_reg, state_next;
    logic [CFG_W-1:0] cfg_reg;
    cnt_t     n_reg;
    cnt_t     occ_reg, occ_next;
    idx_t     i_reg, i_next;
    idx_t     j_reg, j_next;
    cnt_t     step_reg, step_next;
    dist_t    d_reg, d_next;
    key_t     key_reg, key_next;
    key_t     cur_reg, cur_next;
    idx_t     home_reg, home_next;
    logic [1:0] func_reg, func_next;
    logic     found_reg, found_next;
    logic [1:0] status_reg, status_next;
    logic     clr_reg;
    mem_req_t req;
    slot_t    rd;
    logic     cfg_wr;
    cnt_t     n_eff;

    rhhs_store u_store (
        .clk     (clk),
        .req     (req),
        .rd_data (rd)
    );

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
    assign prdata = (paddr == 2'd0) ? {21'd0, cfg_reg} : 32'd0;

    // effective slot count clamped to 1..SLOTS
    always_comb
    begin
        if (cfg_reg == '0)
            n_eff = cnt_t'(1);
        else if ({{(32-CFG_W){1'b0}}, cfg_reg} > 32'(SLOTS))
            n_eff = cnt_t'(SLOTS);
        else
            n_eff = cnt_t'(cfg_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_W'(1024);
            n_reg   <= cnt_t'(SLOTS);
            clr_reg <= 1'b1;
        end
        else
        begin
            if (cfg_wr)
                cfg_reg <= pwdata[CFG_W-1:0];
            n_reg   <= n_eff;
            clr_reg <= cfg_wr;
        end
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            occ_reg   <= '0;
            i_reg     <= '0;
            found_reg <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            i_reg     <= i_next;
            found_reg <= found_next;
            status_reg <= status_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        j_reg    <= j_next;
        step_reg <= step_next;
        d_reg    <= d_next;
        key_reg  <= key_next;
        cur_reg  <= cur_next;
        home_reg <= home_next;
        func_reg <= func_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (valid)
                begin
                    if (func_t'(func) == FUNC_NOP || {1'b0, home_bucket} >= n_reg)
                        state_next = S_DONE;
                    else
                        state_next = S_FRD;
                end
            end
            S_CLEAR:
            begin
                if (i_reg == idx_t'(SLOTS - 1))
                    state_next = S_IDLE;
            end
            S_FRD:  state_next = S_FCHK;
            S_FCHK:
            begin
                if (!rd.valid || (rd.key != key_reg && d_reg > rd.pdist)
                    || step_reg + cnt_t'(1) >= n_reg)
                begin
                    if (rd.valid && rd.key == key_reg)
                        state_next = (func_t'(func_reg) == FUNC_REMOVE) ? S_RRD : S_DONE;
                    else if (func_t'(func_reg) == FUNC_INSERT && occ_reg < n_reg)
                        state_next = S_IRD;
                    else
                        state_next = S_DONE;
                end
                else if (rd.key == key_reg)
                    state_next = (func_t'(func_reg) == FUNC_REMOVE) ? S_RRD : S_DONE;
                else
                    state_next = S_FRD;
            end
            S_IRD:  state_next = S_ICHK;
            S_ICHK:
            begin
                if (!rd.valid || step_reg + cnt_t'(1) >= n_reg)
                    state_next = S_DONE;
                else
                    state_next = S_IRD;
            end
            S_RRD:  state_next = S_RCHK;
            S_RCHK:
            begin
                if (!rd.valid || rd.pdist == '0)
                    state_next = S_DONE;
                else if (step_reg + cnt_t'(1) >= n_reg)
                    state_next = S_RCLR;
                else
                    state_next = S_RRD;
            end
            S_RCLR: state_next = S_DONE;
            S_DONE:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        if (clr_reg)
            state_next = S_CLEAR;
    end

    // datapath and store control
    always_comb
    begin
        occ_next    = occ_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        step_next   = step_reg;
        d_next      = d_reg;
        key_next    = key_reg;
        cur_next    = cur_reg;
        home_next   = home_reg;
        func_next   = func_reg;
        found_next  = found_reg;
        status_next = status_reg;
        req         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                key_next   = key;
                home_next  = home_bucket[IDX_W-1:0];
                func_next  = func;
                i_next     = home_bucket[IDX_W-1:0];
                d_next     = '0;
                step_next  = '0;
                found_next = 1'b0;
                status_next = (func_t'(func) != FUNC_NOP && {1'b0, home_bucket} >= n_reg)
                              ? ST_RANGE : ST_OK;
            end
            S_CLEAR:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = i_reg;
                occ_next    = '0;
                i_next      = i_reg + idx_t'(1);
            end
            S_FRD, S_IRD:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = i_reg;
            end
            S_FCHK:
            begin
                if (rd.valid && rd.key == key_reg)
                begin
                    found_next = 1'b1;
                    j_next     = wrap_next(i_reg, n_reg);
                    step_next  = cnt_t'(1);
                    req.wr_en   = (func_t'(func_reg) == FUNC_REMOVE);
                    req.wr_addr = i_reg;
                    req.wr_data = '{valid: 1'b0, key: rd.key, pdist: rd.pdist};
                end
                else if (!rd.valid || d_reg > rd.pdist || step_reg + cnt_t'(1) >= n_reg)
                begin
                    i_next    = home_reg;
                    d_next    = '0;
                    step_next = '0;
                    cur_next  = key_reg;
                    if (func_t'(func_reg) == FUNC_INSERT && occ_reg >= n_reg)
                        status_next = ST_FULL;
                end
                else
                begin
                    i_next    = wrap_next(i_reg, n_reg);
                    d_next    = d_reg + dist_t'(1);
                    step_next = step_reg + cnt_t'(1);
                end
            end
            S_ICHK:
            begin
                req.wr_addr = i_reg;
                if (!rd.valid)
                begin
                    req.wr_en   = 1'b1;
                    req.wr_data = '{valid: 1'b1, key: cur_reg, pdist: d_reg};
                    occ_next    = occ_reg + cnt_t'(1);
                end
                else
                begin
                    if (d_reg > rd.pdist)
                    begin
                        req.wr_en   = 1'b1;
                        req.wr_data = '{valid: 1'b1, key: cur_reg, pdist: d_reg};
                        cur_next    = rd.key;
                        d_next      = rd.pdist + dist_t'(1);
                    end
                    else
                        d_next = d_reg + dist_t'(1);
                    i_next    = wrap_next(i_reg, n_reg);
                    step_next = step_reg + cnt_t'(1);
                end
            end
            S_RRD:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = j_reg;
            end
            S_RCHK:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = i_reg;
                if (!rd.valid || rd.pdist == '0)
                begin
                    // end of the run: empty the last slot shifted from
                    req.wr_data = '0;
                    if (occ_reg != '0)
                        occ_next = occ_reg - cnt_t'(1);
                end
                else
                begin
                    // shift back: copy j to i, j is emptied later
                    req.wr_data = '{valid: 1'b1, key: rd.key, pdist: rd.pdist - dist_t'(1)};
                    i_next      = j_reg;
                    j_next      = wrap_next(j_reg, n_reg);
                    step_next   = step_reg + cnt_t'(1);
                    cur_next    = rd.key;
                end
            end
            S_RCLR:
            begin
                // shift spanned the whole table: empty the last source slot
                req.wr_en   = 1'b1;
                req.wr_addr = i_reg;
                req.wr_data = '0;
                if (occ_reg != '0)
                    occ_next = occ_reg - cnt_t'(1);
            end
            S_DONE: ;
            default: ;
        endcase
        if (clr_reg)
            i_next = '0;
    end

    // result outputs
    assign ready     = (state_reg == S_IDLE) && !clr_reg;
    assign out_valid = (state_reg == S_DONE);
    assign found     = found_reg;
    assign status    = status_reg;

endmodule

FILE: rtl/rhhs_store.sv
// ----------------------------------------------------------------------------
// rhhs_store: slot memory of the hash set
// One write and one registered read a cycle; holds valid, key and distance.
// ----------------------------------------------------------------------------
module rhhs_store
    import rhhs_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output slot_t    rd_data
);

    slot_t mem [SLOTS];

    // write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

FILE: tb/sv/tb_robin_hood_hash_set.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_robin_hood_hash_set: self-checking bench for the robin hood hash set
// Drives insert, lookup and remove requests over the valid/ready channels and
// predicts found and status with a behavioral table in the scoreboard. The
// slot count register is changed between phases over the APB-style port.
// ----------------------------------------------------------------------------
module tb_robin_hood_hash_set;
    import rhhs_pkg::*;

    // behavioral hash set plus queue of pending answers
    class hash_set_scoreboard;
        bit [10:0]         slot_reg;
        bit [31:0]         keys [SLOTS];
        bit [9:0]          dists [SLOTS];
        bit                used [SLOTS];
        int unsigned       count;
        bit [2:0]          answers [$];
        int                errors;

        function void clear_table();
            foreach (used[i]) used[i] = 1'b0;
            count = 0;
        endfunction

        function void set_slots(bit [10:0] v);
            slot_reg = v;
            clear_table();
        endfunction

        function int unsigned live_slots();
            if (slot_reg == 0) return 1;
            if (slot_reg > SLOTS) return SLOTS;
            return 32'(slot_reg);
        endfunction

        function int unsigned step_slot(int unsigned i, int unsigned n);
            return (i + 1 >= n) ? 0 : i + 1;
        endfunction

        // probe from home, stop early on a richer resident
        function bit locate(bit [31:0] k, int unsigned h, int unsigned n,
                            output int unsigned at);
            int unsigned i;
            i = h;
            at = 0;
            for (int unsigned d = 0; d < n; d++)
            begin
                if (!used[i]) return 0;
                if (keys[i] == k) begin at = i; return 1; end
                if (d > dists[i]) return 0;
                i = step_slot(i, n);
            end
            return 0;
        endfunction

        function void place(bit [31:0] k, int unsigned h, int unsigned n);
            int unsigned i;
            int unsigned d;
            bit [31:0]   tk;
            int unsigned td;
            i = h;
            d = 0;
            for (int unsigned s = 0; s < n; s++)
            begin
                if (!used[i])
                begin
                    used[i] = 1'b1; keys[i] = k; dists[i] = 10'(d); count++;
                    return;
                end
                if (d > dists[i])
                begin
                    tk = keys[i]; td = 32'(dists[i]);
                    keys[i] = k; dists[i] = 10'(d);
                    k = tk; d = td;
                end
                i = step_slot(i, n);
                d++;
            end
        endfunction

        // backward-shift deletion
        function void take_out(int unsigned i, int unsigned n);
            int unsigned j;
            j = step_slot(i, n);
            used[i] = 1'b0;
            for (int unsigned s = 1; s < n; s++)
            begin
                if (!used[j] || dists[j] == 0) break;
                keys[i] = keys[j]; dists[i] = dists[j] - 10'd1;
                used[i] = 1'b1; used[j] = 1'b0;
                i = j;
                j = step_slot(j, n);
            end
            if (count > 0) count--;
        endfunction

        function void note_request(func_t f, bit [31:0] k, bit [9:0] hb);
            int unsigned n;
            int unsigned at;
            bit          hit;
            status_t     st;
            n = live_slots();
            hit = 1'b0;
            st = ST_OK;
            if (f == FUNC_NOP)
                st = ST_OK;
            else if (hb >= n)
                st = ST_RANGE;
            else
            begin
                hit = locate(k, hb, n, at);
                if (f == FUNC_INSERT && !hit)
                begin
                    if (count >= n) st = ST_FULL;
                    else place(k, hb, n);
                end
                else if (f == FUNC_REMOVE && hit)
                    take_out(at, n);
            end
            answers.push_back({hit, st});
        endfunction

        function void check_result(bit f, bit [1:0] s);
            bit [2:0] e;
            if (answers.size() == 0)
            begin
                $error("unexpected result transfer found=%0d status=%0d", f, s);
                errors++;
                return;
            end
            e = answers.pop_front();
            if (f !== e[2])
            begin
                $error("found: expected %0d, actual %0d", e[2], f);
                errors++;
            end
            if (s !== e[1:0])
            begin
                $error("status: expected %0d, actual %0d", e[1:0], s);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] key;
    logic [9:0]  home_bucket;
    logic        out_valid;
    logic        out_ready;
    logic        found;
    logic [1:0]  status;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hash_set_scoreboard sb;
    bit          calm;
    bit [31:0]   key_pool [64];

    robin_hood_hash_set i_dut (
        .clk(clk), .rst_n(rst_n),
        .valid(valid), .ready(ready), .func(func), .key(key),
        .home_bucket(home_bucket),
        .out_valid(out_valid), .out_ready(out_ready), .found(found), .status(status),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("** robin_hood_hash_set: FAILED **");
        $finish;
    end

    // result side: check every transfer, stall in random bursts
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready) sb.check_result(found, status);
            if (stall > 0)
            begin
                stall--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(0, 13);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // register write: setup then access cycle
    task automatic write_slots(bit [10:0] v);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 2'd0; pwdata <= {21'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.set_slots(v);
    endtask

    // wait until every answer has arrived, then let the block settle
    task automatic drain();
        valid <= 1'b0;
        while (sb.answers.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // one request transfer, with an optional random gap before it
    task automatic send(func_t f, bit [31:0] k, bit [9:0] hb);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        valid <= 1'b1; func <= f; key <= k; home_bucket <= hb;
        do @(posedge clk); while (!ready);
        sb.note_request(f, k, hb);
    endtask

    task automatic random_phase(int items, int unsigned n);
        int unsigned r;
        int unsigned kp;
        func_t       f;
        for (int i = 0; i < items; i++)
        begin
            r = $urandom_range(0, 99);
            kp = $urandom_range(0, 63);
            if (r < 45) f = FUNC_INSERT;
            else if (r < 72) f = FUNC_LOOKUP;
            else if (r < 96) f = FUNC_REMOVE;
            else f = FUNC_NOP;
            // home bucket mostly a fixed hash of the key, sometimes random
            if ($urandom_range(0, 15) == 0)
                send(f, $urandom, 10'($urandom));
            else
                send(f, key_pool[kp], 10'((key_pool[kp] ^ (key_pool[kp] >> 7)) % n));
        end
    endtask

    initial
    begin
        sb = new();
        sb.set_slots(11'd1024);
        foreach (key_pool[i]) key_pool[i] = $urandom;
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        calm = 1'b0;
        rst_n = 1'b0;
        valid = 1'b0; func = FUNC_NOP; key = '0; home_bucket = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every code, duplicates, absent remove
        send(FUNC_INSERT, 32'h0, 10'd0);
        send(FUNC_INSERT, 32'hFFFF_FFFF, 10'd1023);
        send(FUNC_INSERT, 32'h0, 10'd0);
        send(FUNC_LOOKUP, 32'hFFFF_FFFF, 10'd1023);
        send(FUNC_INSERT, 32'h5, 10'd1023);
        send(FUNC_INSERT, 32'h6, 10'd1022);
        send(FUNC_LOOKUP, 32'h5, 10'd1023);
        send(FUNC_REMOVE, 32'hFFFF_FFFF, 10'd1023);
        send(FUNC_LOOKUP, 32'h5, 10'd1023);
        send(FUNC_REMOVE, 32'h1234, 10'd7);
        send(FUNC_NOP, 32'hAAAA_5555, 10'h2AA);
        drain();

        // tiny table: fill, reject when full, range errors
        write_slots(11'd3);
        send(FUNC_INSERT, 32'h11, 10'd2);
        send(FUNC_INSERT, 32'h22, 10'd2);
        send(FUNC_INSERT, 32'h33, 10'd1);
        send(FUNC_INSERT, 32'h44, 10'd0);
        send(FUNC_LOOKUP, 32'h33, 10'd1);
        send(FUNC_REMOVE, 32'h11, 10'd2);
        send(FUNC_LOOKUP, 32'h22, 10'd2);
        send(FUNC_INSERT, 32'h55, 10'd3);
        drain();

        // zero acts as one slot, oversize acts as the full table
        write_slots(11'd0);
        send(FUNC_INSERT, 32'h77, 10'd0);
        send(FUNC_INSERT, 32'h78, 10'd0);
        send(FUNC_LOOKUP, 32'h77, 10'd1);
        drain();
        write_slots(11'h7FF);
        send(FUNC_INSERT, 32'h99, 10'd1023);
        drain();

        // random phases at several sizes, ending without idling
        write_slots(11'd1);
        random_phase(40, 1);
        drain();
        write_slots(11'd16);
        random_phase(300, 16);
        drain();
        write_slots(11'd61);
        random_phase(300, 61);
        drain();
        calm = 1'b1;
        write_slots(11'd1024);
        random_phase(260, 1024);
        drain();

        if (sb.errors == 0)
            $display("** robin_hood_hash_set: PASSED **");
        else
            $display("** robin_hood_hash_set: FAILED **");
        $finish;
    end

endmodule
